### design/bmx_pkg.sv
// Shared types and constants of the byte machine execute unit.
package bmx_pkg;

  typedef enum logic [3:0] {
    OP_HALT, OP_IN, OP_OUT, OP_ROR, OP_ROL, OP_NOT, OP_OR, OP_AND,
    OP_NOR, OP_NAND, OP_XOR, OP_ADD, OP_SUB, OP_JZ, OP_JO, OP_BAD
  } func_t;

  typedef enum logic [2:0] {
    MODE_CONST, MODE_REG, MODE_MEM_CONST, MODE_MEM_REG, MODE_LABEL
  } mode_t;

  typedef enum logic [2:0] {
    FLT_OK, FLT_OPCODE, FLT_OPERAND, FLT_RESULT, FLT_REGISTER, FLT_MEMORY, FLT_LABEL
  } fault_t;

  localparam logic [2:0] REG_PROGRAM_LENGTH = 3'd0;
  localparam logic [2:0] REG_CONSTANT_COST  = 3'd1;
  localparam logic [2:0] REG_REGISTER_COST  = 3'd2;
  localparam logic [2:0] REG_MEMORY_COST    = 3'd3;
  localparam logic [2:0] REG_OPERATION_COST = 3'd4;
  localparam logic [2:0] REG_JUMP_COST      = 3'd5;

  localparam int COST_W = 11;

  typedef struct packed {
    logic [8:0] program_length;
    logic [7:0] constant_cost;
    logic [7:0] register_cost;
    logic [7:0] memory_cost;
    logic [7:0] operation_cost;
    logic [7:0] jump_cost;
  } cfg_t;

  typedef struct packed {
    logic [3:0] func;
    logic [2:0] first_mode;
    logic [7:0] first_value;
    logic [2:0] second_mode;
    logic [7:0] second_value;
    logic [2:0] dest_mode;
    logic [7:0] dest_value;
    logic [7:0] port_byte;
    logic       port_fail;
  } item_t;

  typedef struct packed {
    fault_t            fault;
    logic [8:0]        next_pointer;
    logic              out_valid;
    logic [7:0]        out_byte;
    logic              port_taken;
    logic              halted;
    logic [COST_W-1:0] cost;
    logic              rf_we;
    logic              mem_we;
    logic [7:0]        widx;
    logic [7:0]        wdata;
  } exec_t;

endpackage

### design/bmx_dmem.sv
// Data memory with per-entry valid bits, two registered read ports and write bypass.
module bmx_dmem #(
  parameter int WORDS = 256,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr1,
  input  logic [AW-1:0] raddr2,
  output logic [7:0]    rdata1,
  output logic [7:0]    rdata2
);

  logic [7:0]       mem [WORDS];
  logic [WORDS-1:0] vld;
  logic [7:0]       q1;
  logic [7:0]       q2;
  logic             vld1;
  logic             vld2;
  logic             hit1;
  logic             hit2;
  logic [7:0]       wq;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q1 <= mem[raddr1];
      q2 <= mem[raddr2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      vld1 <= vld[raddr1];
      vld2 <= vld[raddr2];
      hit1 <= we && (waddr == raddr1);
      hit2 <= we && (waddr == raddr2);
      wq   <= wdata;
    end
  end

  assign rdata1 = hit1 ? wq : (vld1 ? q1 : 8'd0);
  assign rdata2 = hit2 ? wq : (vld2 ? q2 : 8'd0);

endmodule

### design/bmx_alu.sv
// Operand resolution, fault checks, cost sum and result of one instruction.
module bmx_alu #(
  parameter int REGISTERS     = 8,
  parameter int MEMORY_WORDS  = 256,
  parameter int PROGRAM_DEPTH = 256
) (
  input  bmx_pkg::item_t item,
  input  logic [7:0]     addr1,
  input  logic [7:0]     addr2,
  input  logic [7:0]     mem1,
  input  logic [7:0]     mem2,
  input  logic [7:0]     regfile [REGISTERS],
  input  bmx_pkg::cfg_t  cfg,
  input  logic [8:0]     pointer,
  output bmx_pkg::exec_t ex
);
  import bmx_pkg::*;

  localparam int RF_AW = (REGISTERS > 1) ? $clog2(REGISTERS) : 1;

  typedef struct packed {
    fault_t     fault;
    logic [7:0] val;
    logic [8:0] cost;
  } opnd_t;

  typedef struct packed {
    fault_t     fault;
    logic       is_reg;
    logic [7:0] idx;
    logic [8:0] cost;
  } dest_t;

  function automatic logic reg_ok(logic [7:0] v);
    return {1'b0, v} < 9'(REGISTERS);
  endfunction

  function automatic logic mem_ok(logic [7:0] a);
    return {1'b0, a} < 9'(MEMORY_WORDS);
  endfunction

  function automatic logic [7:0] rf_read(logic [7:0] v);
    logic [7:0] d;
    d = 8'd0;
    if (reg_ok(v)) begin
      d = regfile[v[RF_AW-1:0]];
    end
    return d;
  endfunction

  function automatic opnd_t read_opnd(logic [2:0] mode, logic [7:0] v, logic [7:0] a,
                                      logic [7:0] md, cfg_t c);
    opnd_t o;
    o.fault = FLT_OK;
    o.val   = v;
    o.cost  = 9'd0;
    unique case (mode_t'(mode))
      MODE_CONST: begin
        o.cost = {1'b0, c.constant_cost};
      end
      MODE_REG: begin
        o.cost = {1'b0, c.register_cost};
        if (!reg_ok(v)) o.fault = FLT_REGISTER;
        else            o.val   = rf_read(v);
      end
      MODE_MEM_CONST: begin
        o.cost = {1'b0, c.memory_cost};
        if (!mem_ok(v)) o.fault = FLT_MEMORY;
        else            o.val   = md;
      end
      MODE_MEM_REG: begin
        o.cost = {1'b0, c.register_cost} + {1'b0, c.memory_cost};
        if (!reg_ok(v))      o.fault = FLT_REGISTER;
        else if (!mem_ok(a)) o.fault = FLT_MEMORY;
        else                 o.val   = md;
      end
      default: begin
        o.fault = FLT_OPERAND;
      end
    endcase
    return o;
  endfunction

  function automatic dest_t find_dest(logic [2:0] mode, logic [7:0] v, cfg_t c);
    dest_t d;
    logic [7:0] a;
    d.fault  = FLT_OK;
    d.is_reg = 1'b0;
    d.idx    = v;
    d.cost   = 9'd0;
    a        = rf_read(v);
    unique case (mode_t'(mode))
      MODE_REG: begin
        d.cost   = {1'b0, c.register_cost};
        d.is_reg = 1'b1;
        if (!reg_ok(v)) d.fault = FLT_REGISTER;
      end
      MODE_MEM_CONST: begin
        d.cost = {1'b0, c.memory_cost};
        if (!mem_ok(v)) d.fault = FLT_MEMORY;
      end
      MODE_MEM_REG: begin
        d.cost = {1'b0, c.register_cost} + {1'b0, c.memory_cost};
        d.idx  = a;
        if (!reg_ok(v))      d.fault = FLT_REGISTER;
        else if (!mem_ok(a)) d.fault = FLT_MEMORY;
      end
      default: begin
        d.fault = FLT_RESULT;
      end
    endcase
    return d;
  endfunction

  opnd_t             o1;
  opnd_t             o2;
  dest_t             dst;
  fault_t            f;
  logic [7:0]        x;
  logic [7:0]        y;
  logic [7:0]        r;
  logic [2:0]        n;
  logic [15:0]       rot_r;
  logic [15:0]       rot_l;
  logic [8:0]        halt_tgt;
  logic [8:0]        np;
  logic              outv;
  logic [7:0]        ob;
  logic              pt;
  logic              hl;
  logic              has_dest;
  logic [COST_W-1:0] cost;
  logic [COST_W-1:0] c1;
  logic [COST_W-1:0] c2;
  logic [COST_W-1:0] cd;
  logic [COST_W-1:0] cop;
  logic [COST_W-1:0] cj;

  always_comb begin
    o1  = read_opnd(item.first_mode, item.first_value, addr1, mem1, cfg);
    o2  = read_opnd(item.second_mode, item.second_value, addr2, mem2, cfg);
    dst = find_dest(item.dest_mode, item.dest_value, cfg);
    x   = o1.val;
    y   = o2.val;
    n   = y[2:0];
    rot_r = {x, x} >> n;
    rot_l = {x, x} << n;
    c1  = COST_W'(o1.cost);
    c2  = COST_W'(o2.cost);
    cd  = COST_W'(dst.cost);
    cop = COST_W'(cfg.operation_cost);
    cj  = COST_W'(cfg.jump_cost);
    halt_tgt = (cfg.program_length > 9'(PROGRAM_DEPTH)) ? 9'(PROGRAM_DEPTH)
                                                         : cfg.program_length;
  end

  always_comb begin
    unique case (func_t'(item.func))
      OP_ROR:  r = rot_r[7:0];
      OP_ROL:  r = rot_l[15:8];
      OP_NOT:  r = ~x;
      OP_OR:   r = x | y;
      OP_AND:  r = x & y;
      OP_NOR:  r = ~(x | y);
      OP_NAND: r = ~(x & y);
      OP_XOR:  r = x ^ y;
      OP_ADD:  r = x + y;
      OP_SUB:  r = x - y;
      OP_IN:   r = item.port_byte;
      default: r = 8'd0;
    endcase
  end

  always_comb begin
    f        = FLT_OK;
    np       = pointer + 9'd1;
    outv     = 1'b0;
    ob       = 8'd0;
    pt       = 1'b0;
    hl       = 1'b0;
    has_dest = 1'b0;
    cost     = '0;
    unique case (func_t'(item.func))
      OP_HALT: begin
        np = halt_tgt;
        hl = 1'b1;
      end
      OP_IN: begin
        if (item.port_fail) begin
          np = halt_tgt;
          hl = 1'b1;
        end else begin
          f        = dst.fault;
          has_dest = 1'b1;
          pt       = 1'b1;
          cost     = cd + cop;
        end
      end
      OP_OUT: begin
        f    = o1.fault;
        outv = 1'b1;
        ob   = x;
        cost = c1 + cop;
      end
      OP_NOT: begin
        f        = (o1.fault != FLT_OK) ? o1.fault : dst.fault;
        has_dest = 1'b1;
        cost     = c1 + cd + cop;
      end
      OP_JZ, OP_JO: begin
        f    = o1.fault;
        cost = c1 + cop;
        if ((o1.fault == FLT_OK) &&
            (x == ((func_t'(item.func) == OP_JZ) ? 8'h00 : 8'hFF))) begin
          if (mode_t'(item.dest_mode) != MODE_LABEL) f = FLT_LABEL;
          np   = {1'b0, item.dest_value};
          cost = c1 + cop + cj;
        end
      end
      OP_BAD: begin
        f = FLT_OPCODE;
      end
      default: begin
        if (o1.fault != FLT_OK)      f = o1.fault;
        else if (o2.fault != FLT_OK) f = o2.fault;
        else                         f = dst.fault;
        has_dest = 1'b1;
        cost     = c1 + c2 + cd + cop;
      end
    endcase

    if (f != FLT_OK) begin
      np       = pointer;
      outv     = 1'b0;
      ob       = 8'd0;
      pt       = 1'b0;
      hl       = 1'b0;
      has_dest = 1'b0;
      cost     = '0;
    end
  end

  always_comb begin
    ex.fault        = f;
    ex.next_pointer = np;
    ex.out_valid    = outv;
    ex.out_byte     = ob;
    ex.port_taken   = pt;
    ex.halted       = hl;
    ex.cost         = cost;
    ex.rf_we        = has_dest && dst.is_reg;
    ex.mem_we       = has_dest && !dst.is_reg;
    ex.widx         = dst.idx;
    ex.wdata        = r;
  end

endmodule

### design/byte_machine_execute_unit.sv
// Byte machine execute unit: one instruction per word, with state, config and result register.
//
// Usage:
//   Each input word is the instruction at the current pointer plus the input
//   port byte; it is taken when item_valid is high and item_stall is low.
//   Each word yields exactly one result word on result_valid/result_stall,
//   carrying the next pointer for the outside fetch, the out byte, the
//   port-taken and halted flags, a fault code and the elapsed-time counter.
//   An accepted word waits in the input register, which reads the data
//   memory at accept; at commit the execute logic updates state and loads
//   the result register, with register and memory bypass from the word
//   ahead. Throughput: one word per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds, the word in the
//   input register waits, and item_stall rises until the result is taken.
//   Reset clears pointer, counter, register file and the memory valid bits
//   at once, so all memory entries read as zero; there is no clearing pass.
//   The user writes costs and program length via the APB port only while idle, unenforced.
module byte_machine_execute_unit #(
  parameter int REGISTERS     = 8,
  parameter int MEMORY_WORDS  = 256,
  parameter int PROGRAM_DEPTH = 256,
  parameter int TIME_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [3:0]  func,
  input  logic [2:0]  first_mode,
  input  logic [7:0]  first_value,
  input  logic [2:0]  second_mode,
  input  logic [7:0]  second_value,
  input  logic [2:0]  dest_mode,
  input  logic [7:0]  dest_value,
  input  logic [7:0]  port_byte,
  input  logic        port_fail,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [8:0]  next_pointer,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        port_taken,
  output logic        halted,
  output logic [2:0]  fault,
  output logic [31:0] elapsed
);
  import bmx_pkg::*;

  localparam int RF_AW  = (REGISTERS > 1) ? $clog2(REGISTERS) : 1;
  localparam int MEM_AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;

  cfg_t                  cfg;
  logic                  cfg_wr;
  logic [8:0]            pointer;
  logic [TIME_WIDTH-1:0] time_total;
  logic [TIME_WIDTH-1:0] time_next;
  logic [7:0]            regfile [REGISTERS];
  item_t                 in_item;
  item_t                 s1_item;
  logic [7:0]            s1_addr1;
  logic [7:0]            s1_addr2;
  logic                  s1_valid;
  logic                  accept;
  logic                  commit;
  logic [7:0]            addr1;
  logic [7:0]            addr2;
  logic [7:0]            mem1;
  logic [7:0]            mem2;
  exec_t                 ex;

  function automatic logic [7:0] rf_fwd(logic [7:0] v);
    logic [7:0] d;
    d = 8'd0;
    if ({1'b0, v} < 9'(REGISTERS)) begin
      d = regfile[v[RF_AW-1:0]];
    end
    if (commit && ex.rf_we && (ex.widx == v)) begin
      d = ex.wdata;
    end
    return d;
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.program_length <= 9'd0;
      cfg.constant_cost  <= 8'd1;
      cfg.register_cost  <= 8'd1;
      cfg.memory_cost    <= 8'd1;
      cfg.operation_cost <= 8'd1;
      cfg.jump_cost      <= 8'd1;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_PROGRAM_LENGTH: cfg.program_length <= pwdata[8:0];
        REG_CONSTANT_COST:  cfg.constant_cost  <= pwdata[7:0];
        REG_REGISTER_COST:  cfg.register_cost  <= pwdata[7:0];
        REG_MEMORY_COST:    cfg.memory_cost    <= pwdata[7:0];
        REG_OPERATION_COST: cfg.operation_cost <= pwdata[7:0];
        REG_JUMP_COST:      cfg.jump_cost      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PROGRAM_LENGTH: prdata = {23'd0, cfg.program_length};
      REG_CONSTANT_COST:  prdata = {24'd0, cfg.constant_cost};
      REG_REGISTER_COST:  prdata = {24'd0, cfg.register_cost};
      REG_MEMORY_COST:    prdata = {24'd0, cfg.memory_cost};
      REG_OPERATION_COST: prdata = {24'd0, cfg.operation_cost};
      REG_JUMP_COST:      prdata = {24'd0, cfg.jump_cost};
      default:            prdata = 32'd0;
    endcase
  end

  // Handshake
  assign commit     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !commit;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    in_item.func         = func;
    in_item.first_mode   = first_mode;
    in_item.first_value  = first_value;
    in_item.second_mode  = second_mode;
    in_item.second_value = second_value;
    in_item.dest_mode    = dest_mode;
    in_item.dest_value   = dest_value;
    in_item.port_byte    = port_byte;
    in_item.port_fail    = port_fail;
  end

  assign addr1 = (mode_t'(first_mode) == MODE_MEM_REG) ? rf_fwd(first_value) : first_value;
  assign addr2 = (mode_t'(second_mode) == MODE_MEM_REG) ? rf_fwd(second_value) : second_value;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= in_item;
      s1_addr1 <= addr1;
      s1_addr2 <= addr2;
    end
  end

  bmx_dmem #(
    .WORDS (MEMORY_WORDS)
  ) u_dmem (
    .clk    (clk),
    .rst    (rst),
    .we     (commit && ex.mem_we),
    .waddr  (ex.widx[MEM_AW-1:0]),
    .wdata  (ex.wdata),
    .re     (accept),
    .raddr1 (addr1[MEM_AW-1:0]),
    .raddr2 (addr2[MEM_AW-1:0]),
    .rdata1 (mem1),
    .rdata2 (mem2)
  );

  bmx_alu #(
    .REGISTERS     (REGISTERS),
    .MEMORY_WORDS  (MEMORY_WORDS),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_alu (
    .item    (s1_item),
    .addr1   (s1_addr1),
    .addr2   (s1_addr2),
    .mem1    (mem1),
    .mem2    (mem2),
    .regfile (regfile),
    .cfg     (cfg),
    .pointer (pointer),
    .ex      (ex)
  );

  // Machine state
  assign time_next = time_total + TIME_WIDTH'(ex.cost);

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer    <= 9'd0;
      time_total <= '0;
      for (int i = 0; i < REGISTERS; i++) begin
        regfile[i] <= 8'd0;
      end
    end else if (commit) begin
      pointer    <= ex.next_pointer;
      time_total <= time_next;
      if (ex.rf_we) begin
        regfile[ex.widx[RF_AW-1:0]] <= ex.wdata;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      next_pointer <= ex.next_pointer;
      out_valid    <= ex.out_valid;
      out_byte     <= ex.out_byte;
      port_taken   <= ex.port_taken;
      halted       <= ex.halted;
      fault        <= ex.fault;
      elapsed      <= 32'(time_next);
    end
  end

  a_fault_keeps_state: assert property (@(posedge clk) disable iff (rst)
    commit && (ex.fault != FLT_OK) |=> $stable(pointer) && $stable(time_total))
    else $error("faulting word changed pointer or counter");

  a_elapsed_tracks: assert property (@(posedge clk) disable iff (rst)
    commit |=> elapsed == 32'(time_total))
    else $error("elapsed differs from counter");

  a_pointer_tracks: assert property (@(posedge clk) disable iff (rst)
    commit |=> next_pointer == pointer)
    else $error("next_pointer differs from pointer");

  a_halt_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && halted |-> (fault == FLT_OK) && !out_valid && !port_taken)
    else $error("halt result carries side effects");

endmodule

### test/byte_machine_execute_unit_test.sv
// Self-checking testbench of the byte machine execute unit: directed table, then random words.
`timescale 1ns / 100ps

module byte_machine_execute_unit_test;
  import bmx_pkg::*;

  localparam int REG_COUNT = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int WATCHDOG = 2000;
  localparam logic [2:0] MODE_JUNK = 3'd7;

  typedef struct packed {
    logic [8:0]  next_pointer;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        port_taken;
    logic        halted;
    fault_t      fault;
    logic [31:0] elapsed;
  } exp_t;

  typedef struct {
    item_t w;
    bit    known;
    exp_t  typed;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [3:0]  func = '0;
  logic [2:0]  first_mode = '0;
  logic [7:0]  first_value = '0;
  logic [2:0]  second_mode = '0;
  logic [7:0]  second_value = '0;
  logic [2:0]  dest_mode = '0;
  logic [7:0]  dest_value = '0;
  logic [7:0]  port_byte = '0;
  logic        port_fail = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [8:0]  next_pointer;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        port_taken;
  logic        halted;
  logic [2:0]  fault;
  logic [31:0] elapsed;

  byte_machine_execute_unit u_top (.*);

  always #1 clk = ~clk;

  // machine state and register copy
  cfg_t        cfg_now = '{9'd0, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
  logic [8:0]  pointer_copy = '0;
  logic [31:0] time_copy = '0;
  logic [7:0]  regs_copy [REG_COUNT] = '{default: 8'h00};
  logic [7:0]  mem_copy [256] = '{default: 8'h00};

  exp_t  pending_results [$];
  row_t  dir_rows [$];
  exp_t  observed, awaited;
  int    pace = 1;
  bit    hold_wanted = 1'b0;
  bit    hold_served = 1'b0;
  int    stall_run = 0;
  int    stall_roll;
  int    idle_cycles;
  int    words_sent = 0;
  int    results_checked = 0;
  int    mismatches = 0;
  int    faults_seen = 0;
  int    halts_seen = 0;
  int    settings_count = 0;

  function automatic fault_t fetch_operand(input logic [2:0] mode, input logic [7:0] v,
                                           inout logic [63:0] t, output logic [7:0] val);
    val = 8'h00;
    case (mode)
      MODE_CONST: begin
        t += 64'(cfg_now.constant_cost);
        val = v;
      end
      MODE_REG: begin
        t += 64'(cfg_now.register_cost);
        if (v >= REG_COUNT) return FLT_REGISTER;
        val = regs_copy[v[2:0]];
      end
      MODE_MEM_CONST: begin
        t += 64'(cfg_now.memory_cost);
        val = mem_copy[v];
      end
      MODE_MEM_REG: begin
        t += 64'(cfg_now.register_cost) + 64'(cfg_now.memory_cost);
        if (v >= REG_COUNT) return FLT_REGISTER;
        val = mem_copy[regs_copy[v[2:0]]];
      end
      default: return FLT_OPERAND;
    endcase
    return FLT_OK;
  endfunction

  function automatic fault_t locate_dest(input logic [2:0] mode, input logic [7:0] v,
                                         inout logic [63:0] t, output logic to_reg,
                                         output logic [7:0] idx);
    to_reg = 1'b0;
    idx = 8'h00;
    case (mode)
      MODE_REG: begin
        t += 64'(cfg_now.register_cost);
        if (v >= REG_COUNT) return FLT_REGISTER;
        to_reg = 1'b1;
        idx = v;
      end
      MODE_MEM_CONST: begin
        t += 64'(cfg_now.memory_cost);
        idx = v;
      end
      MODE_MEM_REG: begin
        t += 64'(cfg_now.register_cost) + 64'(cfg_now.memory_cost);
        if (v >= REG_COUNT) return FLT_REGISTER;
        idx = regs_copy[v[2:0]];
      end
      default: return FLT_RESULT;
    endcase
    return FLT_OK;
  endfunction

  function automatic exp_t execute_word(input item_t w);
    logic [63:0] t;
    logic [8:0]  np;
    logic [8:0]  stop;
    fault_t      flt;
    logic [7:0]  x, y, r, idx;
    logic [15:0] twice;
    logic        has_dest, to_reg;
    exp_t        e;
    t = {32'd0, time_copy};
    np = pointer_copy + 9'd1;
    stop = (cfg_now.program_length > 9'd256) ? 9'd256 : cfg_now.program_length;
    flt = FLT_OK;
    x = 8'h00;
    y = 8'h00;
    r = 8'h00;
    idx = 8'h00;
    has_dest = 1'b0;
    to_reg = 1'b0;
    e = '0;
    case (func_t'(w.func))
      OP_HALT: begin
        np = stop;
        e.halted = 1'b1;
      end
      OP_IN: begin
        if (w.port_fail) begin
          np = stop;
          e.halted = 1'b1;
        end else begin
          flt = locate_dest(w.dest_mode, w.dest_value, t, to_reg, idx);
          r = w.port_byte;
          has_dest = 1'b1;
          e.port_taken = 1'b1;
          t += 64'(cfg_now.operation_cost);
        end
      end
      OP_OUT: begin
        flt = fetch_operand(w.first_mode, w.first_value, t, x);
        e.out_valid = 1'b1;
        e.out_byte = x;
        t += 64'(cfg_now.operation_cost);
      end
      OP_NOT: begin
        flt = fetch_operand(w.first_mode, w.first_value, t, x);
        if (flt == FLT_OK) flt = locate_dest(w.dest_mode, w.dest_value, t, to_reg, idx);
        r = ~x;
        has_dest = 1'b1;
        t += 64'(cfg_now.operation_cost);
      end
      OP_JZ, OP_JO: begin
        flt = fetch_operand(w.first_mode, w.first_value, t, x);
        if (flt == FLT_OK && x == ((w.func == OP_JZ) ? 8'h00 : 8'hFF)) begin
          if (w.dest_mode != MODE_LABEL) flt = FLT_LABEL;
          np = {1'b0, w.dest_value};
          t += 64'(cfg_now.jump_cost);
        end
        t += 64'(cfg_now.operation_cost);
      end
      OP_BAD: flt = FLT_OPCODE;
      default: begin
        flt = fetch_operand(w.first_mode, w.first_value, t, x);
        if (flt == FLT_OK) flt = fetch_operand(w.second_mode, w.second_value, t, y);
        if (flt == FLT_OK) flt = locate_dest(w.dest_mode, w.dest_value, t, to_reg, idx);
        twice = {x, x};
        case (func_t'(w.func))
          OP_ROR: begin
            twice = twice >> y[2:0];
            r = twice[7:0];
          end
          OP_ROL: begin
            twice = twice << y[2:0];
            r = twice[15:8];
          end
          OP_OR:   r = x | y;
          OP_AND:  r = x & y;
          OP_NOR:  r = ~(x | y);
          OP_NAND: r = ~(x & y);
          OP_XOR:  r = x ^ y;
          OP_ADD:  r = x + y;
          default: r = x - y;
        endcase
        has_dest = 1'b1;
        t += 64'(cfg_now.operation_cost);
      end
    endcase
    if (flt != FLT_OK) begin
      e = '0;
      e.next_pointer = pointer_copy;
      e.elapsed = time_copy;
    end else begin
      if (has_dest) begin
        if (to_reg) regs_copy[idx[2:0]] = r;
        else mem_copy[idx] = r;
      end
      pointer_copy = np;
      time_copy = t[31:0];
      e.next_pointer = np;
      e.elapsed = time_copy;
    end
    e.fault = flt;
    return e;
  endfunction

  function automatic item_t make_word(input func_t f, input logic [2:0] m1,
                                      input logic [7:0] v1, input logic [2:0] m2,
                                      input logic [7:0] v2, input logic [2:0] md,
                                      input logic [7:0] vd, input logic [7:0] pb,
                                      input logic pf);
    item_t w;
    w.func = f;
    w.first_mode = m1;
    w.first_value = v1;
    w.second_mode = m2;
    w.second_value = v2;
    w.dest_mode = md;
    w.dest_value = vd;
    w.port_byte = pb;
    w.port_fail = pf;
    return w;
  endfunction

  function automatic logic [2:0] pick_source_mode();
    int r = $urandom_range(0, 99);
    if (r < 20) return MODE_CONST;
    if (r < 45) return MODE_REG;
    if (r < 65) return MODE_MEM_CONST;
    if (r < 90) return MODE_MEM_REG;
    if (r < 94) return MODE_LABEL;
    return 3'($urandom_range(5, 7));
  endfunction

  function automatic logic [2:0] pick_dest_mode();
    int r = $urandom_range(0, 99);
    if (r < 40) return MODE_REG;
    if (r < 65) return MODE_MEM_CONST;
    if (r < 90) return MODE_MEM_REG;
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] pick_value(input logic [2:0] mode);
    int r = $urandom_range(0, 99);
    if (mode == MODE_REG || mode == MODE_MEM_REG)
      return (r < 94) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(8, 255));
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t random_word();
    item_t w;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 3) w.func = OP_HALT;
    else if (r < 5) w.func = OP_BAD;
    else if (r < 15) w.func = OP_IN;
    else if (r < 23) w.func = OP_OUT;
    else if (r < 31) w.func = OP_JZ;
    else if (r < 39) w.func = OP_JO;
    else w.func = 4'($urandom_range(int'(OP_ROR), int'(OP_SUB)));
    w.first_mode = pick_source_mode();
    w.first_value = pick_value(w.first_mode);
    w.second_mode = pick_source_mode();
    w.second_value = pick_value(w.second_mode);
    w.dest_mode = pick_dest_mode();
    w.dest_value = pick_value(w.dest_mode);
    w.port_byte = 8'($urandom_range(0, 255));
    w.port_fail = ($urandom_range(0, 99) < 15);
    if (w.func == OP_JZ || w.func == OP_JO) begin
      w.dest_mode = ($urandom_range(0, 99) < 90) ? MODE_LABEL : pick_dest_mode();
      w.dest_value = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 40) begin
        w.first_mode = MODE_CONST;
        w.first_value = (w.func == OP_JZ) ? 8'h00 : 8'hFF;
      end
    end
    return w;
  endfunction

  function automatic int idle_len();
    int r = $urandom_range(0, 99);
    int calm = (pace == 2) ? 45 : 70;
    if (pace == 0 || r < calm) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic deliver(input item_t w, input bit known, input exp_t typed);
    int   gap;
    exp_t e;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    func <= w.func;
    first_mode <= w.first_mode;
    first_value <= w.first_value;
    second_mode <= w.second_mode;
    second_value <= w.second_value;
    dest_mode <= w.dest_mode;
    dest_value <= w.dest_value;
    port_byte <= w.port_byte;
    port_fail <= w.port_fail;
    do @(posedge clk); while (item_stall);
    e = execute_word(w);
    pending_results.push_back(known ? typed : e);
    words_sent++;
    if (e.fault != FLT_OK) faults_seen++;
    if (e.halted) halts_seen++;
  endtask

  task automatic run_random(input int count);
    repeat (count) deliver(random_word(), 1'b0, '0);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PROGRAM_LENGTH: cfg_now.program_length = value[8:0];
      REG_CONSTANT_COST:  cfg_now.constant_cost = value[7:0];
      REG_REGISTER_COST:  cfg_now.register_cost = value[7:0];
      REG_MEMORY_COST:    cfg_now.memory_cost = value[7:0];
      REG_OPERATION_COST: cfg_now.operation_cost = value[7:0];
      REG_JUMP_COST:      cfg_now.jump_cost = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      if (mismatches < 10)
        $display("%0t register %0d read back %h, wrote %h", $realtime, idx, readback, value);
      mismatches++;
    end
  endtask

  // drain, then load a full register set
  task automatic apply_settings(input cfg_t c);
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_register(REG_PROGRAM_LENGTH, 32'(c.program_length));
    write_register(REG_CONSTANT_COST, 32'(c.constant_cost));
    write_register(REG_REGISTER_COST, 32'(c.register_cost));
    write_register(REG_MEMORY_COST, 32'(c.memory_cost));
    write_register(REG_OPERATION_COST, 32'(c.operation_cost));
    write_register(REG_JUMP_COST, 32'(c.jump_cost));
    settings_count++;
  endtask

  always @(negedge clk) begin
    stall_roll = $urandom_range(0, 99);
    if (stall_run > 0) begin
      result_stall <= 1'b1;
      stall_run--;
    end else if (hold_wanted && !hold_served) begin
      hold_served = 1'b1;
      stall_run = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (pace == 0 || stall_roll < ((pace == 2) ? 45 : 70)) begin
      result_stall <= 1'b0;
    end else if (stall_roll < 95) begin
      stall_run = $urandom_range(0, 2);
      result_stall <= 1'b1;
    end else begin
      stall_run = $urandom_range(9, 39);
      result_stall <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      observed = exp_t'{next_pointer, out_valid, out_byte, port_taken, halted,
                        fault_t'(fault), elapsed};
      results_checked++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10) $display("%0t result word with nothing pending", $realtime);
        mismatches++;
      end else begin
        awaited = pending_results.pop_front();
        if (observed !== awaited) begin
          if (mismatches < 10) begin
            $display("%0t mismatch exp: ptr=%0d ov=%0d ob=%h pt=%0d h=%0d f=%0d el=%0d",
                     $realtime, awaited.next_pointer, awaited.out_valid, awaited.out_byte,
                     awaited.port_taken, awaited.halted, awaited.fault, awaited.elapsed);
            $display("%0t          got: ptr=%0d ov=%0d ob=%h pt=%0d h=%0d f=%0d el=%0d",
                     $realtime, observed.next_pointer, observed.out_valid, observed.out_byte,
                     observed.port_taken, observed.halted, observed.fault, observed.elapsed);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("byte_machine_execute_unit_test failed");
    $finish;
  end

  initial begin
    // reset values of the machine: pointer 0, elapsed 0, all costs 1
    dir_rows.push_back(row_t'{make_word(OP_HALT, MODE_CONST, 8'h00, MODE_CONST, 8'h00,
        MODE_CONST, 8'h00, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b1, FLT_OK, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_BAD, MODE_CONST, 8'hFF, MODE_CONST, 8'hFF,
        MODE_REG, 8'h00, 8'hFF, 1'b1), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_OPCODE, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_OR, MODE_LABEL, 8'h00, MODE_CONST, 8'h00,
        MODE_REG, 8'h00, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_OPERAND, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_AND, MODE_CONST, 8'h0F, MODE_JUNK, 8'h00,
        MODE_REG, 8'h01, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_OPERAND, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_NOT, MODE_CONST, 8'h5A, MODE_CONST, 8'h00,
        MODE_CONST, 8'h03, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_RESULT, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_XOR, MODE_CONST, 8'h12, MODE_CONST, 8'h34,
        MODE_LABEL, 8'h05, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_RESULT, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_ADD, MODE_REG, 8'h08, MODE_CONST, 8'h01,
        MODE_REG, 8'h00, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_REGISTER, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_SUB, MODE_CONST, 8'h01, MODE_REG, 8'hFF,
        MODE_REG, 8'h00, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_REGISTER, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_NAND, MODE_CONST, 8'h01, MODE_CONST, 8'h02,
        MODE_MEM_REG, 8'h09, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_REGISTER, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_JO, MODE_CONST, 8'hFF, MODE_CONST, 8'h00,
        MODE_CONST, 8'h10, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b0, FLT_LABEL, 32'd0}});
    dir_rows.push_back(row_t'{make_word(OP_IN, MODE_JUNK, 8'h00, MODE_JUNK, 8'h00,
        MODE_REG, 8'h00, 8'hFF, 1'b0), 1'b1,
        exp_t'{9'd1, 1'b0, 8'h00, 1'b1, 1'b0, FLT_OK, 32'd2}});
    dir_rows.push_back(row_t'{make_word(OP_OUT, MODE_REG, 8'h00, MODE_JUNK, 8'hFF,
        MODE_JUNK, 8'hFF, 8'h00, 1'b1), 1'b1,
        exp_t'{9'd2, 1'b1, 8'hFF, 1'b0, 1'b0, FLT_OK, 32'd4}});
    dir_rows.push_back(row_t'{make_word(OP_IN, MODE_JUNK, 8'h00, MODE_CONST, 8'h00,
        MODE_REG, 8'h01, 8'hA5, 1'b1), 1'b1,
        exp_t'{9'd0, 1'b0, 8'h00, 1'b0, 1'b1, FLT_OK, 32'd4}});
    dir_rows.push_back(row_t'{make_word(OP_JZ, MODE_CONST, 8'h01, MODE_CONST, 8'h00,
        MODE_JUNK, 8'h40, 8'h00, 1'b0), 1'b1,
        exp_t'{9'd1, 1'b0, 8'h00, 1'b0, 1'b0, FLT_OK, 32'd6}});
    dir_rows.push_back(row_t'{make_word(OP_ADD, MODE_CONST, 8'hFF, MODE_CONST, 8'h01,
        MODE_REG, 8'h01, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_SUB, MODE_CONST, 8'h00, MODE_CONST, 8'h01,
        MODE_MEM_CONST, 8'hFF, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_ROR, MODE_CONST, 8'h81, MODE_CONST, 8'h09,
        MODE_REG, 8'h02, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_ROL, MODE_CONST, 8'h81, MODE_CONST, 8'h07,
        MODE_MEM_REG, 8'h01, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_NOT, MODE_MEM_CONST, 8'hFF, MODE_LABEL, 8'h00,
        MODE_REG, 8'h03, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_OR, MODE_REG, 8'h02, MODE_MEM_REG, 8'h01,
        MODE_REG, 8'h04, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_NOR, MODE_MEM_CONST, 8'h00, MODE_CONST, 8'h00,
        MODE_REG, 8'h05, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_NAND, MODE_REG, 8'h00, MODE_REG, 8'h00,
        MODE_REG, 8'h07, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_XOR, MODE_CONST, 8'hAA, MODE_CONST, 8'h55,
        MODE_MEM_CONST, 8'h80, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_JZ, MODE_REG, 8'h03, MODE_JUNK, 8'h00,
        MODE_LABEL, 8'hC8, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_JO, MODE_REG, 8'h00, MODE_JUNK, 8'h00,
        MODE_REG, 8'h20, 8'h00, 1'b0), 1'b0, '0});
    dir_rows.push_back(row_t'{make_word(OP_OUT, MODE_MEM_REG, 8'h07, MODE_JUNK, 8'h00,
        3'd6, 8'h00, 8'h00, 1'b0), 1'b0, '0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pace = 1;
    foreach (dir_rows[i]) deliver(dir_rows[i].w, dir_rows[i].known, dir_rows[i].typed);

    apply_settings('{9'd12, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5});
    run_random(180);

    // free costs, walk the pointer from the halt point past its wrap
    apply_settings('{9'd256, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
    pace = 0;
    deliver(make_word(OP_HALT, MODE_CONST, 8'h00, MODE_CONST, 8'h00, MODE_CONST, 8'h00,
                      8'h00, 1'b0), 1'b0, '0);
    repeat (260)
      deliver(make_word(OP_OUT, MODE_CONST, 8'($urandom_range(0, 255)), MODE_CONST, 8'h00,
                        MODE_CONST, 8'h00, 8'h00, 1'b0), 1'b0, '0);
    run_random(150);

    apply_settings('{9'd511, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
    pace = 2;
    run_random(180);

    apply_settings('{9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))});
    pace = 1;
    hold_wanted = 1'b1;
    run_random(180);

    apply_settings('{9'd300, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255))});
    pace = 2;
    run_random(180);

    apply_settings('{9'($urandom_range(0, 256)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))});
    pace = 1;
    run_random(180);

    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("ran %0d instruction words under %0d register sets, %0d faulting, %0d halting",
             words_sent, settings_count + 1, faults_seen, halts_seen);
    $display("checked %0d result words, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("byte_machine_execute_unit_test passed");
    end else begin
      $display("byte_machine_execute_unit_test failed");
    end
    $finish;
  end

endmodule
